@@ src/assert_macros.svh @@
// Assertion macros for the RTL of the line estimate fusion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define LEF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lef: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define LEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lef: next-cycle check failed");

`endif

@@ src/lef_pkg.sv @@
// Types, operand codes and the fusion microprogram for the line estimate fusion block.
`default_nettype none

package lef_pkg;

  // Width of the signed working registers; every exact intermediate fits.
  localparam int WIDE_W = 232;
  localparam int WORD_W = 32;
  localparam int UCODE_LEN = 44;

  typedef logic [11:0][WORD_W-1:0] lef_scal_t;
  typedef logic [5:0][WORD_W-1:0]  lef_res_t;

  typedef struct packed {
    logic done;
    logic singular;
  } lef_status_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_CHK
  } lef_op_t;

  typedef enum logic [1:0] {
    ACC_SET,
    ACC_ADD,
    ACC_SUB
  } lef_acc_t;

  // Operand codes: wide scratch registers below 16, input scalars above.
  localparam logic [4:0] SRC_DA   = 5'd0;
  localparam logic [4:0] SRC_DB   = 5'd1;
  localparam logic [4:0] SRC_M0   = 5'd2;
  localparam logic [4:0] SRC_N1   = 5'd3;
  localparam logic [4:0] SRC_N2   = 5'd4;
  localparam logic [4:0] SRC_M3   = 5'd5;
  localparam logic [4:0] SRC_UA0  = 5'd6;
  localparam logic [4:0] SRC_UA1  = 5'd7;
  localparam logic [4:0] SRC_UB0  = 5'd8;
  localparam logic [4:0] SRC_UB1  = 5'd9;
  localparam logic [4:0] SRC_V0   = 5'd10;
  localparam logic [4:0] SRC_V1   = 5'd11;
  localparam logic [4:0] SRC_DADB = 5'd12;
  localparam logic [4:0] SRC_DM   = 5'd13;
  localparam logic [4:0] SRC_TMP  = 5'd14;
  localparam logic [4:0] SRC_A0   = 5'd16;
  localparam logic [4:0] SRC_A1   = 5'd17;
  localparam logic [4:0] SRC_A2   = 5'd18;
  localparam logic [4:0] SRC_A3   = 5'd19;
  localparam logic [4:0] SRC_P0   = 5'd20;
  localparam logic [4:0] SRC_P1   = 5'd21;
  localparam logic [4:0] SRC_B0   = 5'd22;
  localparam logic [4:0] SRC_B1   = 5'd23;
  localparam logic [4:0] SRC_B2   = 5'd24;
  localparam logic [4:0] SRC_B3   = 5'd25;
  localparam logic [4:0] SRC_Q0   = 5'd26;
  localparam logic [4:0] SRC_Q1   = 5'd27;

  // Result slots, in output order.
  localparam logic [2:0] RES_ANGLE = 3'd0;
  localparam logic [2:0] RES_RANGE = 3'd1;
  localparam logic [2:0] RES_CAA   = 3'd2;
  localparam logic [2:0] RES_CAR   = 3'd3;
  localparam logic [2:0] RES_CRA   = 3'd4;
  localparam logic [2:0] RES_CRR   = 3'd5;

  typedef struct packed {
    lef_op_t    op;
    lef_acc_t   mode;
    logic [4:0] src_a;
    logic [4:0] src_b;
    logic       wr;
    logic [3:0] dst;
    logic [2:0] slot;
    logic       last;
  } lef_uop_t;

  function automatic lef_uop_t lef_mk(input lef_op_t op, input lef_acc_t mode,
                                      input logic [4:0] a, input logic [4:0] b,
                                      input logic wr, input logic [4:0] dst,
                                      input logic [2:0] slot, input logic last);
    lef_uop_t r;
    r.op    = op;
    r.mode  = mode;
    r.src_a = a;
    r.src_b = b;
    r.wr    = wr;
    r.dst   = dst[3:0];
    r.slot  = slot;
    r.last  = last;
    return r;
  endfunction

  // Limb count minus one of an operand's magnitude.
  function automatic logic [1:0] lef_limbs(input logic [4:0] src);
    logic [1:0] n;
    n = 2'd0;
    if (!src[4]) begin
      unique case (src)
        SRC_DA, SRC_DB, SRC_UA0, SRC_UA1, SRC_UB0, SRC_UB1: n = 2'd1;
        SRC_M0, SRC_N1, SRC_N2, SRC_M3:                     n = 2'd2;
        SRC_V0, SRC_V1, SRC_DADB:                           n = 2'd3;
        default:                                            n = 2'd0;
      endcase
    end
    return n;
  endfunction

  // Fusion program: determinants and their zero checks, weighted sum matrix, its
  // adjugate and determinant (also checked), weighted parameter vectors, then six rounded divisions.
  function automatic lef_uop_t lef_ucode(input logic [5:0] pc);
    lef_uop_t u;
    unique case (pc)
      6'd0:  u = lef_mk(OP_MUL, ACC_SET, SRC_A0, SRC_A3, 1'b0, SRC_DA, RES_ANGLE, 1'b0);
      6'd1:  u = lef_mk(OP_MUL, ACC_SUB, SRC_A1, SRC_A2, 1'b1, SRC_DA, RES_ANGLE, 1'b0);
      6'd2:  u = lef_mk(OP_MUL, ACC_SET, SRC_B0, SRC_B3, 1'b0, SRC_DB, RES_ANGLE, 1'b0);
      6'd3:  u = lef_mk(OP_MUL, ACC_SUB, SRC_B1, SRC_B2, 1'b1, SRC_DB, RES_ANGLE, 1'b0);
      6'd4:  u = lef_mk(OP_CHK, ACC_SET, SRC_DA, SRC_DA, 1'b0, SRC_DA, RES_ANGLE, 1'b0);
      6'd5:  u = lef_mk(OP_CHK, ACC_SET, SRC_DB, SRC_DB, 1'b0, SRC_DA, RES_ANGLE, 1'b0);
      6'd6:  u = lef_mk(OP_MUL, ACC_SET, SRC_DB, SRC_A3, 1'b0, SRC_M0, RES_ANGLE, 1'b0);
      6'd7:  u = lef_mk(OP_MUL, ACC_ADD, SRC_DA, SRC_B3, 1'b1, SRC_M0, RES_ANGLE, 1'b0);
      6'd8:  u = lef_mk(OP_MUL, ACC_SET, SRC_DB, SRC_A1, 1'b0, SRC_N1, RES_ANGLE, 1'b0);
      6'd9:  u = lef_mk(OP_MUL, ACC_ADD, SRC_DA, SRC_B1, 1'b1, SRC_N1, RES_ANGLE, 1'b0);
      6'd10: u = lef_mk(OP_MUL, ACC_SET, SRC_DB, SRC_A2, 1'b0, SRC_N2, RES_ANGLE, 1'b0);
      6'd11: u = lef_mk(OP_MUL, ACC_ADD, SRC_DA, SRC_B2, 1'b1, SRC_N2, RES_ANGLE, 1'b0);
      6'd12: u = lef_mk(OP_MUL, ACC_SET, SRC_DB, SRC_A0, 1'b0, SRC_M3, RES_ANGLE, 1'b0);
      6'd13: u = lef_mk(OP_MUL, ACC_ADD, SRC_DA, SRC_B0, 1'b1, SRC_M3, RES_ANGLE, 1'b0);
      6'd14: u = lef_mk(OP_MUL, ACC_SET, SRC_M0, SRC_M3, 1'b0, SRC_DM, RES_ANGLE, 1'b0);
      6'd15: u = lef_mk(OP_MUL, ACC_SUB, SRC_N1, SRC_N2, 1'b1, SRC_DM, RES_ANGLE, 1'b0);
      6'd16: u = lef_mk(OP_CHK, ACC_SET, SRC_DM, SRC_DM, 1'b0, SRC_DA, RES_ANGLE, 1'b0);
      6'd17: u = lef_mk(OP_MUL, ACC_SET, SRC_A3, SRC_P0, 1'b0, SRC_UA0, RES_ANGLE, 1'b0);
      6'd18: u = lef_mk(OP_MUL, ACC_SUB, SRC_A1, SRC_P1, 1'b1, SRC_UA0, RES_ANGLE, 1'b0);
      6'd19: u = lef_mk(OP_MUL, ACC_SET, SRC_A0, SRC_P1, 1'b0, SRC_UA1, RES_ANGLE, 1'b0);
      6'd20: u = lef_mk(OP_MUL, ACC_SUB, SRC_A2, SRC_P0, 1'b1, SRC_UA1, RES_ANGLE, 1'b0);
      6'd21: u = lef_mk(OP_MUL, ACC_SET, SRC_B3, SRC_Q0, 1'b0, SRC_UB0, RES_ANGLE, 1'b0);
      6'd22: u = lef_mk(OP_MUL, ACC_SUB, SRC_B1, SRC_Q1, 1'b1, SRC_UB0, RES_ANGLE, 1'b0);
      6'd23: u = lef_mk(OP_MUL, ACC_SET, SRC_B0, SRC_Q1, 1'b0, SRC_UB1, RES_ANGLE, 1'b0);
      6'd24: u = lef_mk(OP_MUL, ACC_SUB, SRC_B2, SRC_Q0, 1'b1, SRC_UB1, RES_ANGLE, 1'b0);
      6'd25: u = lef_mk(OP_MUL, ACC_SET, SRC_DB, SRC_UA0, 1'b0, SRC_V0, RES_ANGLE, 1'b0);
      6'd26: u = lef_mk(OP_MUL, ACC_ADD, SRC_DA, SRC_UB0, 1'b1, SRC_V0, RES_ANGLE, 1'b0);
      6'd27: u = lef_mk(OP_MUL, ACC_SET, SRC_DB, SRC_UA1, 1'b0, SRC_V1, RES_ANGLE, 1'b0);
      6'd28: u = lef_mk(OP_MUL, ACC_ADD, SRC_DA, SRC_UB1, 1'b1, SRC_V1, RES_ANGLE, 1'b0);
      6'd29: u = lef_mk(OP_MUL, ACC_SET, SRC_M3, SRC_V0, 1'b0, SRC_TMP, RES_ANGLE, 1'b0);
      6'd30: u = lef_mk(OP_MUL, ACC_ADD, SRC_N1, SRC_V1, 1'b1, SRC_TMP, RES_ANGLE, 1'b0);
      6'd31: u = lef_mk(OP_DIV, ACC_SET, SRC_TMP, SRC_DM, 1'b0, SRC_DA, RES_ANGLE, 1'b0);
      6'd32: u = lef_mk(OP_MUL, ACC_SET, SRC_N2, SRC_V0, 1'b0, SRC_TMP, RES_ANGLE, 1'b0);
      6'd33: u = lef_mk(OP_MUL, ACC_ADD, SRC_M0, SRC_V1, 1'b1, SRC_TMP, RES_ANGLE, 1'b0);
      6'd34: u = lef_mk(OP_DIV, ACC_SET, SRC_TMP, SRC_DM, 1'b0, SRC_DA, RES_RANGE, 1'b0);
      6'd35: u = lef_mk(OP_MUL, ACC_SET, SRC_DA, SRC_DB, 1'b1, SRC_DADB, RES_ANGLE, 1'b0);
      6'd36: u = lef_mk(OP_MUL, ACC_SET, SRC_DADB, SRC_M3, 1'b1, SRC_TMP, RES_ANGLE, 1'b0);
      6'd37: u = lef_mk(OP_DIV, ACC_SET, SRC_TMP, SRC_DM, 1'b0, SRC_DA, RES_CAA, 1'b0);
      6'd38: u = lef_mk(OP_MUL, ACC_SET, SRC_DADB, SRC_N1, 1'b1, SRC_TMP, RES_ANGLE, 1'b0);
      6'd39: u = lef_mk(OP_DIV, ACC_SET, SRC_TMP, SRC_DM, 1'b0, SRC_DA, RES_CAR, 1'b0);
      6'd40: u = lef_mk(OP_MUL, ACC_SET, SRC_DADB, SRC_N2, 1'b1, SRC_TMP, RES_ANGLE, 1'b0);
      6'd41: u = lef_mk(OP_DIV, ACC_SET, SRC_TMP, SRC_DM, 1'b0, SRC_DA, RES_CRA, 1'b0);
      6'd42: u = lef_mk(OP_MUL, ACC_SET, SRC_DADB, SRC_M0, 1'b1, SRC_TMP, RES_ANGLE, 1'b0);
      6'd43: u = lef_mk(OP_DIV, ACC_SET, SRC_TMP, SRC_DM, 1'b0, SRC_DA, RES_CRR, 1'b1);
      default: u = lef_mk(OP_CHK, ACC_SET, SRC_DA, SRC_DA, 1'b0, SRC_DA, RES_ANGLE, 1'b1);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

@@ src/lef_core.sv @@
// Microcoded fusion engine: one 32x32 multiplier and one wide adder under a sequencer.
`default_nettype none

module lef_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire lef_pkg::lef_scal_t  scal,
  output lef_pkg::lef_status_t     status,
  output lef_pkg::lef_res_t        res
);

  localparam int W = lef_pkg::WIDE_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_ABSA,
    S_ABSB,
    S_MUL,
    S_MFLUSH,
    S_MACC,
    S_DIVPREP,
    S_DIV,
    S_DIVEND,
    S_DONE
  } state_t;

  state_t           state;
  logic [5:0]       pc;
  lef_pkg::lef_uop_t uop;

  logic [W-1:0]     opa, opb;
  logic             sa, sb;
  logic [W-1:0]     pacc, acc, rem, dsh;
  logic [63:0]      pp;
  logic [2:0]       pp_sh;
  logic             pp_v;
  logic [1:0]       li, lj, na, nb;
  logic [5:0]       kcnt;
  logic [32:0]      quo;
  logic             singular_r;

  // Scratch register file and its registered read ports
  logic [W-1:0]     rf [16];
  logic [W-1:0]     rd_a, rd_b;

  logic [W-1:0]     a_val, b_val;
  logic [W-1:0]     add_x, add_y;
  logic             add_sub;
  logic [W:0]       add_sum;
  logic [63:0]      mprod;
  logic [W-1:0]     pp_ext;
  logic             div_neg;
  logic [31:0]      div_word;

  assign uop = lef_pkg::lef_ucode(pc);

  // Pick a scalar input, sign extended, or the register file word
  function automatic logic [W-1:0] pick(input logic [4:0] src, input logic [W-1:0] rd,
                                        input lef_pkg::lef_scal_t s);
    logic [31:0] w;
    w = s[src[3:0]];
    return src[4] ? {{(W-32){w[31]}}, w} : rd;
  endfunction

  assign a_val = pick(uop.src_a, rd_a, scal);
  assign b_val = pick(uop.src_b, rd_b, scal);

  // Limb product and its aligned form
  assign mprod  = 64'(opa[{li, 5'b0} +: 32]) * 64'(opb[{lj, 5'b0} +: 32]);
  assign pp_ext = W'(pp) << {pp_sh, 5'b0};

  // Shared adder operand selection
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state)
      S_ABSA: begin
        add_y   = opa;
        add_sub = 1'b1;
      end
      S_ABSB: begin
        add_y   = opb;
        add_sub = 1'b1;
      end
      S_MUL, S_MFLUSH: begin
        add_x = pacc;
        add_y = pp_v ? pp_ext : '0;
      end
      S_MACC: begin
        add_x   = (uop.mode == lef_pkg::ACC_SET) ? '0 : acc;
        add_y   = pacc;
        add_sub = (sa ^ sb) ^ (uop.mode == lef_pkg::ACC_SUB);
      end
      S_DIVPREP: begin
        add_x = {opa[W-2:0], 1'b0};
        add_y = opb;
      end
      S_DIV: begin
        add_x   = rem;
        add_y   = dsh;
        add_sub = 1'b1;
      end
      default: begin
        add_x   = '0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {W{add_sub}}} + (W+1)'(add_sub);

  // Round-to-nearest quotient, saturated to a signed word
  assign div_neg = sa ^ sb;
  always_comb begin
    if (!div_neg) begin
      div_word = (quo > 33'h07FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
    end else begin
      div_word = (quo > 33'h080000000) ? 32'h80000000 : 32'd0 - quo[31:0];
    end
  end

  // Register file write and read
  always_ff @(posedge clk) begin
    if (state == S_MACC && uop.wr) begin
      rf[uop.dst] <= add_sum[W-1:0];
    end
    if (state == S_FETCH) begin
      rd_a <= rf[uop.src_a[3:0]];
      rd_b <= rf[uop.src_b[3:0]];
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pc         <= '0;
      singular_r <= 1'b0;
      pp_v       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pc         <= '0;
            singular_r <= 1'b0;
            state      <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          opa <= a_val;
          opb <= b_val;
          if (uop.op == lef_pkg::OP_CHK) begin
            if (a_val == '0) begin
              singular_r <= 1'b1;
              state      <= S_DONE;
            end else begin
              pc    <= pc + 6'd1;
              state <= S_FETCH;
            end
          end else begin
            state <= S_ABSA;
          end
        end
        S_ABSA: begin
          sa <= opa[W-1];
          if (opa[W-1]) opa <= add_sum[W-1:0];
          state <= S_ABSB;
        end
        S_ABSB: begin
          sb <= opb[W-1];
          if (opb[W-1]) opb <= add_sum[W-1:0];
          if (uop.op == lef_pkg::OP_DIV) begin
            state <= S_DIVPREP;
          end else begin
            pacc  <= '0;
            pp_v  <= 1'b0;
            li    <= '0;
            lj    <= '0;
            na    <= lef_pkg::lef_limbs(uop.src_a);
            nb    <= lef_pkg::lef_limbs(uop.src_b);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          pacc  <= add_sum[W-1:0];
          pp    <= mprod;
          pp_sh <= {1'b0, li} + {1'b0, lj};
          pp_v  <= 1'b1;
          if (lj == nb) begin
            lj <= '0;
            if (li == na) begin
              state <= S_MFLUSH;
            end else begin
              li <= li + 2'd1;
            end
          end else begin
            lj <= lj + 2'd1;
          end
        end
        S_MFLUSH: begin
          pacc  <= add_sum[W-1:0];
          pp_v  <= 1'b0;
          state <= S_MACC;
        end
        S_MACC: begin
          acc   <= add_sum[W-1:0];
          pc    <= pc + 6'd1;
          state <= S_FETCH;
        end
        S_DIVPREP: begin
          rem   <= add_sum[W-1:0];
          dsh   <= {opb[W-34:0], 33'b0};
          quo   <= '0;
          kcnt  <= 6'd32;
          state <= S_DIV;
        end
        S_DIV: begin
          if (add_sum[W]) rem <= add_sum[W-1:0];
          quo <= {quo[31:0], add_sum[W]};
          dsh <= {1'b0, dsh[W-1:1]};
          if (kcnt == 6'd0) begin
            state <= S_DIVEND;
          end else begin
            kcnt <= kcnt - 6'd1;
          end
        end
        S_DIVEND: begin
          res[uop.slot] <= div_word;
          if (uop.last) begin
            state <= S_DONE;
          end else begin
            pc    <= pc + 6'd1;
            state <= S_FETCH;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status.done     = (state == S_DONE);
  assign status.singular = singular_r;

endmodule

`default_nettype wire

@@ src/line_estimate_fusion_2d.sv @@
// Top level of the line estimate fusion block: handshakes, stored estimate, result register.
`default_nettype none
`include "assert_macros.svh"

// Keeps one line estimate (angle and distance in Q16.16, 2x2 covariance in
// Q8.24) and returns it after every input word. A load word (kind 0) replaces
// the estimate, which the result stage then registers once the output register
// is free. A fuse word (kind 1) is worked by a microcoded engine built around one
// 32x32 multiplier and one 232-bit adder: 35 multiply-accumulate steps and six
// 33-step restoring divisions; a fuse that meets a zero determinant stops early,
// keeps the estimate and flags singular. in_ready is high only while no word is
// in work; a finished result sits in the output register until taken, and the
// next word may be accepted meanwhile.
module line_estimate_fusion_2d (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic signed [31:0] obs_angle,
  input  wire logic signed [31:0] obs_range,
  input  wire logic signed [31:0] obs_cov_aa,
  input  wire logic signed [31:0] obs_cov_ar,
  input  wire logic signed [31:0] obs_cov_ra,
  input  wire logic signed [31:0] obs_cov_rr,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      est_angle,
  output logic signed [31:0]      est_range,
  output logic signed [31:0]      est_cov_aa,
  output logic signed [31:0]      est_cov_ar,
  output logic signed [31:0]      est_cov_ra,
  output logic signed [31:0]      est_cov_rr,
  output logic                    singular
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_OUT
  } tstate_t;

  tstate_t               tstate;
  logic [31:0]           stored_angle, stored_range;
  logic [3:0][31:0]      stored_cov;
  logic [31:0]           ob_angle, ob_range;
  logic [3:0][31:0]      ob_cov;
  logic                  sing_pend;
  logic                  in_fire;
  logic                  start;
  lef_pkg::lef_scal_t    scal;
  lef_pkg::lef_status_t  core_status;
  lef_pkg::lef_res_t     core_res;

  assign in_ready = (tstate == T_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign start    = in_fire && kind;

  // Assemble the engine's scalar operands
  always_comb begin
    scal[0]  = stored_cov[0];
    scal[1]  = stored_cov[1];
    scal[2]  = stored_cov[2];
    scal[3]  = stored_cov[3];
    scal[4]  = stored_angle;
    scal[5]  = stored_range;
    scal[6]  = ob_cov[0];
    scal[7]  = ob_cov[1];
    scal[8]  = ob_cov[2];
    scal[9]  = ob_cov[3];
    scal[10] = ob_angle;
    scal[11] = ob_range;
  end

  lef_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .scal   (scal),
    .status (core_status),
    .res    (core_res)
  );

  // Control, stored estimate and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate       <= T_IDLE;
      stored_angle <= '0;
      stored_range <= '0;
      stored_cov   <= '0;
      sing_pend    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Drop a taken word unless the result stage refills the register now
      if (out_valid && out_ready && tstate != T_OUT) out_valid <= 1'b0;
      unique case (tstate)
        T_IDLE: begin
          if (in_fire) begin
            if (kind) begin
              ob_angle  <= obs_angle;
              ob_range  <= obs_range;
              ob_cov[0] <= obs_cov_aa;
              ob_cov[1] <= obs_cov_ar;
              ob_cov[2] <= obs_cov_ra;
              ob_cov[3] <= obs_cov_rr;
              tstate    <= T_RUN;
            end else begin
              stored_angle  <= obs_angle;
              stored_range  <= obs_range;
              stored_cov[0] <= obs_cov_aa;
              stored_cov[1] <= obs_cov_ar;
              stored_cov[2] <= obs_cov_ra;
              stored_cov[3] <= obs_cov_rr;
              sing_pend     <= 1'b0;
              tstate        <= T_OUT;
            end
          end
        end
        T_RUN: begin
          if (core_status.done) begin
            if (!core_status.singular) begin
              stored_angle  <= core_res[lef_pkg::RES_ANGLE];
              stored_range  <= core_res[lef_pkg::RES_RANGE];
              stored_cov[0] <= core_res[lef_pkg::RES_CAA];
              stored_cov[1] <= core_res[lef_pkg::RES_CAR];
              stored_cov[2] <= core_res[lef_pkg::RES_CRA];
              stored_cov[3] <= core_res[lef_pkg::RES_CRR];
            end
            sing_pend <= core_status.singular;
            tstate    <= T_OUT;
          end
        end
        T_OUT: begin
          if (!out_valid || out_ready) begin
            est_angle  <= $signed(stored_angle);
            est_range  <= $signed(stored_range);
            est_cov_aa <= $signed(stored_cov[0]);
            est_cov_ar <= $signed(stored_cov[1]);
            est_cov_ra <= $signed(stored_cov[2]);
            est_cov_rr <= $signed(stored_cov[3]);
            singular   <= sing_pend;
            out_valid  <= 1'b1;
            tstate     <= T_IDLE;
          end
        end
        default: begin
          tstate <= T_IDLE;
        end
      endcase
    end
  end

  // The engine only finishes while a fuse word is in work
  `LEF_ASSERT_IMPL(a_done_in_run, core_status.done, tstate == T_RUN)
  // The estimate holds while the engine is still working
  `LEF_ASSERT_NEXT(a_state_hold, (tstate == T_RUN) && !core_status.done,
                   $stable(stored_angle) && $stable(stored_range) && $stable(stored_cov))
  // A new result word appears only from the result stage
  `LEF_ASSERT_IMPL(a_out_from_stage, $rose(out_valid), $past(tstate == T_OUT))

endmodule

`default_nettype wire
